### rtl/ppm_pkg.sv
// shared types and constants for the rgb to packed pixel converter
// no dependencies; imported by ppm_lane, ppm_merge and the top level
package ppm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 8;
    localparam int NUM_W     = SAMPLE_W + CHAN_W;
    localparam int DIV_STEPS = CHAN_W;
    localparam int WORD_W    = 32;
    localparam int LANES     = 3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = 16'hffff;
    localparam logic [CHAN_W-1:0]   CHAN_FULL   = 8'hff;

    // configuration register indexes
    localparam logic [2:0] CFG_SAMPLE_MAX   = 3'd0;
    localparam logic [2:0] CFG_BYTES        = 3'd1;
    localparam logic [2:0] CFG_RED_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_RED_LENGTH   = 3'd3;
    localparam logic [2:0] CFG_GREEN_OFFSET = 3'd4;
    localparam logic [2:0] CFG_GREEN_LENGTH = 3'd5;
    localparam logic [2:0] CFG_BLUE_OFFSET  = 3'd6;
    localparam logic [2:0] CFG_BLUE_LENGTH  = 3'd7;

    typedef struct packed {
        logic [4:0] offset;
        logic [3:0] length;
    } field_cfg_t;

    typedef struct packed {
        logic [2:0] bytes_per_pixel;
        field_cfg_t red;
        field_cfg_t green;
        field_cfg_t blue;
    } pack_cfg_t;

endpackage

### rtl/ppm_lane.sv
// one channel lane: scales a 16-bit sample to 8 bits against sample_max
// restoring divider, one quotient bit per stage; depends on ppm_pkg
module ppm_lane
    import ppm_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STEPS:0]    stage_en,
    input  logic [SAMPLE_W-1:0]   sample_max,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic [CHAN_W-1:0]     chan
);

    logic [NUM_W-1:0]  rem_reg  [0:DIV_STEPS];
    logic [CHAN_W-1:0] quot_reg [0:DIV_STEPS];
    logic              spec_reg [0:DIV_STEPS];
    logic [CHAN_W-1:0] sval_reg [0:DIV_STEPS];

    logic [NUM_W-1:0]  rem_next  [0:DIV_STEPS];
    logic [CHAN_W-1:0] quot_next [0:DIV_STEPS];
    logic              spec_next [0:DIV_STEPS];
    logic [CHAN_W-1:0] sval_next [0:DIV_STEPS];

    logic [NUM_W-1:0]  divisor [1:DIV_STEPS];

    always_comb
    begin
        // entry stage: numerator sample*255 and the cases that skip the divide
        rem_next[0]  = {sample, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, sample};
        quot_next[0] = '0;
        if (sample_max == SAMPLE_FULL)
        begin
            spec_next[0] = 1'b1;
            sval_next[0] = sample[SAMPLE_W-1 -: CHAN_W];
        end
        else if (sample_max == '0)
        begin
            spec_next[0] = 1'b1;
            sval_next[0] = (sample != '0) ? CHAN_FULL : '0;
        end
        else if (sample > sample_max)
        begin
            spec_next[0] = 1'b1;
            sval_next[0] = CHAN_FULL;
        end
        else
        begin
            spec_next[0] = 1'b0;
            sval_next[0] = '0;
        end

        // divide stages, most significant quotient bit first
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            divisor[k] = {{CHAN_W{1'b0}}, sample_max} << (DIV_STEPS - k);
            if (rem_reg[k-1] >= divisor[k])
            begin
                rem_next[k]  = rem_reg[k-1] - divisor[k];
                quot_next[k] = {quot_reg[k-1][CHAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_reg[k-1];
                quot_next[k] = {quot_reg[k-1][CHAN_W-2:0], 1'b0};
            end
            spec_next[k] = spec_reg[k-1];
            sval_next[k] = sval_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            if (stage_en[k])
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
                spec_reg[k] <= spec_next[k];
                sval_reg[k] <= sval_next[k];
            end
        end
    end

    assign chan = spec_reg[DIV_STEPS] ? sval_reg[DIV_STEPS] : quot_reg[DIV_STEPS];

endmodule

### rtl/ppm_merge.sv
// merge stage: places the three channels in the packed word and masks bytes
// registered output with its own valid; depends on ppm_pkg
module ppm_merge
    import ppm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              valid_in,
    input  pack_cfg_t         cfg,
    input  logic [CHAN_W-1:0] red_chan,
    input  logic [CHAN_W-1:0] green_chan,
    input  logic [CHAN_W-1:0] blue_chan,
    output logic              out_valid,
    output logic [WORD_W-1:0] packed_word,
    output logic [2:0]        bytes_valid
);

    logic              out_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [2:0]        nb_reg;
    logic [2:0]        nb_next;
    logic [WORD_W-1:0] fields;

    function automatic logic [WORD_W-1:0] place_field(
        input logic [CHAN_W-1:0] chan_in,
        input field_cfg_t        fc
    );
        logic [3:0]        len_c;
        logic [CHAN_W-1:0] kept;
        len_c = (fc.length > 4'd8) ? 4'd8 : fc.length;
        kept = chan_in >> (4'd8 - len_c);
        place_field = {{(WORD_W-CHAN_W){1'b0}}, kept} << fc.offset;
    endfunction

    always_comb
    begin
        if (cfg.bytes_per_pixel == 3'd0)
            nb_next = 3'd1;
        else if (cfg.bytes_per_pixel inside {[3'd5:3'd7]})
            nb_next = 3'd4;
        else
            nb_next = cfg.bytes_per_pixel;

        fields = place_field(red_chan, cfg.red)
               | place_field(green_chan, cfg.green)
               | place_field(blue_chan, cfg.blue);

        case (nb_next)
            3'd1:    word_next = {24'd0, fields[7:0]};
            3'd2:    word_next = {16'd0, fields[15:0]};
            3'd3:    word_next = {8'd0, fields[23:0]};
            default: word_next = fields;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
            nb_reg   <= nb_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_word = word_reg;
    assign bytes_valid = nb_reg;

endmodule

### rtl/ppm_to_packed_pixel_unit.sv
// top level of the rgb sample to packed pixel converter
// holds configuration and pipeline control; uses ppm_pkg, ppm_lane, ppm_merge
//
//  port group   handshake             payload
//  input        in_valid / in_ready   red_sample, green_sample, blue_sample
//  output       out_valid / out_ready packed_word, bytes_valid
//  config       cfg_write             cfg_index, cfg_data (no wait)
//
// one item per clock while the output is not stalled; the stages are the
// entry stage, 8 divide stages (one quotient bit each, three lanes side by
// side) and the output register. each stage loads when it is empty or its
// item moves on in the same cycle, so bubbles are squeezed out and an item
// is taken while a finished result waits; in_ready drops only when all ten
// stages hold items and the output is stalled. reset empties the pipeline
// and loads the register defaults.
module ppm_to_packed_pixel_unit
    import ppm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [SAMPLE_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] red_sample,
    input  logic [SAMPLE_W-1:0] green_sample,
    input  logic [SAMPLE_W-1:0] blue_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   packed_word,
    output logic [2:0]          bytes_valid
);

    logic [SAMPLE_W-1:0] sample_max_reg;
    pack_cfg_t           cfg_reg;

    logic [DIV_STEPS:0]   valid_reg;
    logic [DIV_STEPS+1:0] can_load;
    logic [CHAN_W-1:0]    chan [0:LANES-1];
    logic [SAMPLE_W-1:0]  lane_sample [0:LANES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_max_reg         <= 16'd255;
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.red            <= '{offset: 5'd16, length: 4'd8};
            cfg_reg.green          <= '{offset: 5'd8,  length: 4'd8};
            cfg_reg.blue           <= '{offset: 5'd0,  length: 4'd8};
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SAMPLE_MAX:   sample_max_reg          <= cfg_data;
                CFG_BYTES:        cfg_reg.bytes_per_pixel <= cfg_data[2:0];
                CFG_RED_OFFSET:   cfg_reg.red.offset      <= cfg_data[4:0];
                CFG_RED_LENGTH:   cfg_reg.red.length      <= cfg_data[3:0];
                CFG_GREEN_OFFSET: cfg_reg.green.offset    <= cfg_data[4:0];
                CFG_GREEN_LENGTH: cfg_reg.green.length    <= cfg_data[3:0];
                CFG_BLUE_OFFSET:  cfg_reg.blue.offset     <= cfg_data[4:0];
                CFG_BLUE_LENGTH:  cfg_reg.blue.length     <= cfg_data[3:0];
                default:          sample_max_reg          <= sample_max_reg;
            endcase
        end
    end

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        can_load[DIV_STEPS+1] = !out_valid || out_ready;
        for (int k = DIV_STEPS; k >= 0; k--)
            can_load[k] = !valid_reg[k] || can_load[k+1];
    end

    assign in_ready = can_load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (can_load[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++)
                if (can_load[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign lane_sample[0] = red_sample;
    assign lane_sample[1] = green_sample;
    assign lane_sample[2] = blue_sample;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ppm_lane u_lane (
            .clk        (clk),
            .stage_en   (can_load[DIV_STEPS:0]),
            .sample_max (sample_max_reg),
            .sample     (lane_sample[i]),
            .chan       (chan[i])
        );
    end

    ppm_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (can_load[DIV_STEPS+1]),
        .valid_in    (valid_reg[DIV_STEPS]),
        .cfg         (cfg_reg),
        .red_chan    (chan[0]),
        .green_chan  (chan[1]),
        .blue_chan   (chan[2]),
        .out_valid   (out_valid),
        .packed_word (packed_word),
        .bytes_valid (bytes_valid)
    );

    // a full pipeline with a stalled output must refuse new items
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && (&valid_reg)) |-> !in_ready)
        else $error("item taken into a full stalled pipeline");

    // an empty entry stage always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> in_ready)
        else $error("entry stage empty but not ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bytes_valid == 3'd1 || bytes_valid == 3'd2 ||
                       bytes_valid == 3'd3 || bytes_valid == 3'd4))
        else $error("byte count out of range");

    // with a reported count of one, the bytes beyond it are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bytes_valid == 3'd1) |-> (packed_word[31:8] == 24'd0))
        else $error("unused bytes not cleared");

    // an item accepted into an empty pipeline lands in the entry stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && (valid_reg == '0) && in_valid && in_ready)
        |=> valid_reg[0])
        else $error("accepted item lost at entry");

endmodule
